### design/uule_pkg.sv
// uule_pkg: word types, character constants and slot layout for the uuencode line encoder.
// Depends on nothing; used by every module in the design folder.
`default_nettype none

package uule_pkg;

  // Character constants
  localparam logic [7:0] CHAR_ZERO   = 8'h60;  // stands in for a zero sextet
  localparam logic [7:0] CHAR_OFFSET = 8'h20;
  localparam logic [7:0] CHAR_CR     = 8'h0d;
  localparam logic [7:0] CHAR_LF     = 8'h0a;  // counted in the text sum at each line end

  // Largest byte count that the length character may carry
  localparam logic [5:0] MAX_LINE_BYTES = 6'd45;

  // Character slots of one group: length, four data characters, carriage return
  localparam int NUM_SLOTS = 6;
  localparam int NUM_DATA  = 4;
  localparam int SLOT_LEN  = 0;
  localparam int SLOT_DATA = 1;
  localparam int SLOT_CR   = 5;

  typedef struct packed {
    logic [7:0] byte_a;
    logic [7:0] byte_b;
    logic [7:0] byte_c;
    logic [1:0] real_bytes;
    logic [5:0] line_bytes;
    logic       first_group;
    logic       last_group;
    logic       clear_section_sum;
    logic       clear_file_sum;
  } in_word_t;

  typedef struct packed {
    logic [7:0]  out_char;
    logic        run_end;
    logic [15:0] source_checksum;
    logic [15:0] encoded_checksum;
  } out_word_t;

  // One encoded group, held between the lanes and the merging stage
  typedef struct packed {
    logic [NUM_SLOTS-1:0][7:0] chars;
    logic [NUM_SLOTS-1:0]      present;
    logic [2:0][7:0]           data_bytes;  // padding already forced to zero
    logic [1:0]                real_bytes;
    logic                      last_group;
    logic                      clear_section_sum;
    logic                      clear_file_sum;
  } stage_t;

  typedef struct packed {
    logic [15:0] source_sum;
    logic [15:0] encoded_sum;
  } sums_t;

endpackage

`default_nettype wire

### design/uuencode_line_with_bsd_sum.sv
// uuencode_line_with_bsd_sum: top level, encode lanes, merge stage and character output register.
// Depends on uule_pkg, uule_lane and uule_merge.
`default_nettype none

// Encodes uuencode lines one group of up to three bytes per input word and sends one
// character per output word: the length character on a line's first group, four data
// characters when the group holds real bytes, and a carriage return on its last group.
// Every output word carries both running BSD sum -r checksums as they stand after its
// group, and run_end marks the group's final character. The output port moves one
// character a cycle while out_ready is high; a group yields 0 to 6 characters, four
// for a full group inside a line. A group that yields no character still advances the
// checksums but sends no output word. A group passes through the encode stage register
// and then the output register, and the next group is taken while the present one is
// still being sent.
module uuencode_line_with_bsd_sum (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire uule_pkg::in_word_t in_word,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output uule_pkg::out_word_t    out_word
);
  import uule_pkg::*;

  // Encode stage
  logic [7:0]                b_real;
  logic [7:0]                c_real;
  logic [5:0]                len_val;
  logic [NUM_DATA-1:0][5:0]  sextets;
  logic [NUM_DATA-1:0][7:0]  data_chars;
  logic [7:0]                len_char;
  stage_t                    stage_nxt;
  stage_t                    stage_r;
  logic                      stage_valid_r;
  logic                      stage_valid_nxt;
  logic                      stage_move;

  // Checksum state and output register
  sums_t                     sums_r;
  sums_t                     sums_nxt;
  sums_t                     out_sums_r;
  logic [NUM_SLOTS-1:0][7:0] out_chars_r;
  logic [NUM_SLOTS-1:0]      out_mask_r;
  logic [NUM_SLOTS-1:0]      out_mask_nxt;
  logic [NUM_SLOTS-1:0]      pick;
  logic [NUM_SLOTS-1:0]      rest;
  logic [7:0]                pick_char;
  logic                      out_take;
  logic                      out_free;

  // Padding bytes count as zero; the length saturates
  assign b_real  = (in_word.real_bytes >= 2'd2) ? in_word.byte_b : 8'd0;
  assign c_real  = (in_word.real_bytes == 2'd3) ? in_word.byte_c : 8'd0;
  assign len_val = (in_word.line_bytes > MAX_LINE_BYTES) ? MAX_LINE_BYTES
                                                         : in_word.line_bytes;

  assign sextets[0] = in_word.byte_a[7:2];
  assign sextets[1] = {in_word.byte_a[1:0], b_real[7:4]};
  assign sextets[2] = {b_real[3:0], c_real[7:6]};
  assign sextets[3] = c_real[5:0];

  // One lane per data character, plus one for the length character
  for (genvar g = 0; g < NUM_DATA; g++) begin : g_lane
    uule_lane u_lane (
      .sextet   (sextets[g]),
      .enc_char (data_chars[g])
    );
  end

  uule_lane u_len_lane (
    .sextet   (len_val),
    .enc_char (len_char)
  );

  // Pack the group into fixed slots with a presence mask
  always_comb begin
    stage_nxt.chars[SLOT_LEN] = len_char;
    for (int k = 0; k < NUM_DATA; k++) begin
      stage_nxt.chars[SLOT_DATA + k] = data_chars[k];
    end
    stage_nxt.chars[SLOT_CR]   = CHAR_CR;
    stage_nxt.present[SLOT_LEN] = in_word.first_group;
    for (int k = 0; k < NUM_DATA; k++) begin
      stage_nxt.present[SLOT_DATA + k] = (in_word.real_bytes != 2'd0);
    end
    stage_nxt.present[SLOT_CR]   = in_word.last_group;
    stage_nxt.data_bytes[0]      = in_word.byte_a;
    stage_nxt.data_bytes[1]      = b_real;
    stage_nxt.data_bytes[2]      = c_real;
    stage_nxt.real_bytes         = in_word.real_bytes;
    stage_nxt.last_group         = in_word.last_group;
    stage_nxt.clear_section_sum  = in_word.clear_section_sum;
    stage_nxt.clear_file_sum     = in_word.clear_file_sum;
  end

  // Merge stage: checksums advance as a group enters the output register
  uule_merge u_merge (
    .stage    (stage_r),
    .sums     (sums_r),
    .sums_nxt (sums_nxt)
  );

  // Output selection: lowest pending slot goes first
  assign pick = out_mask_r & (~out_mask_r + 6'd1);
  assign rest = out_mask_r & (out_mask_r - 6'd1);

  always_comb begin
    pick_char = 8'd0;
    for (int k = 0; k < NUM_SLOTS; k++) begin
      if (pick[k]) begin
        pick_char = pick_char | out_chars_r[k];
      end
    end
  end

  assign out_valid                 = (out_mask_r != '0);
  assign out_word.out_char         = pick_char;
  assign out_word.run_end          = (rest == '0);
  assign out_word.source_checksum  = out_sums_r.source_sum;
  assign out_word.encoded_checksum = out_sums_r.encoded_sum;

  // Handshake
  assign out_take   = out_valid && out_ready;
  assign out_free   = !out_valid || (out_take && (rest == '0));
  assign stage_move = stage_valid_r && out_free;
  assign in_ready   = !stage_valid_r || stage_move;

  always_comb begin
    stage_valid_nxt = stage_valid_r;
    if (in_valid && in_ready) begin
      stage_valid_nxt = 1'b1;
    end else if (stage_move) begin
      stage_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_mask_nxt = out_mask_r;
    if (stage_move) begin
      out_mask_nxt = stage_r.present;
    end else if (out_take) begin
      out_mask_nxt = rest;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
      out_mask_r    <= '0;
      sums_r        <= '0;
    end else begin
      stage_valid_r <= stage_valid_nxt;
      out_mask_r    <= out_mask_nxt;
      if (stage_move) begin
        sums_r <= sums_nxt;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_r <= stage_nxt;
    end
    if (stage_move) begin
      out_chars_r <= stage_r.chars;
      out_sums_r  <= sums_nxt;
    end
  end

  // Checks
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |-> (!stage_valid_r || stage_move))
    else $error("encode stage overwritten before it moved on");

  a_run_end_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (out_take && out_word.run_end && !stage_move) |=> !out_valid)
    else $error("output still valid after the last character of a group");

  a_sums_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && !stage_move) |=> ($stable(sums_r.source_sum) && $stable(sums_r.encoded_sum)))
    else $error("checksum changed without a group entering the output register");

  a_group_nonempty_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_take && !out_word.run_end) |=> out_valid)
    else $error("group ended before its final character");

endmodule

`default_nettype wire

### design/uule_lane.sv
// uule_lane: maps one 6-bit value to its printable uuencode character.
// Depends on uule_pkg for the character constants.
`default_nettype none

module uule_lane (
  input  wire logic [5:0] sextet,
  output logic      [7:0] enc_char
);
  import uule_pkg::*;

  // Zero goes to the backquote, anything else is offset into printable range
  always_comb begin
    if (sextet == 6'd0) begin
      enc_char = CHAR_ZERO;
    end else begin
      enc_char = {2'b00, sextet} + CHAR_OFFSET;
    end
  end

endmodule

`default_nettype wire

### design/uule_merge.sv
// uule_merge: folds one encoded group into the two running BSD sum -r checksums.
// Depends on uule_pkg for stage_t, sums_t and the slot layout.
`default_nettype none

module uule_merge (
  input  wire uule_pkg::stage_t stage,
  input  wire uule_pkg::sums_t  sums,
  output uule_pkg::sums_t       sums_nxt
);
  import uule_pkg::*;

  // Rotate right by one, then add the byte, modulo 2^16
  function automatic logic [15:0] sum_step(input logic [15:0] s, input logic [7:0] b);
    return {s[0], s[15:1]} + {8'd0, b};
  endfunction

  logic [15:0] src;
  logic [15:0] enc;

  always_comb begin
    // Source sum over the real bytes only
    src = stage.clear_file_sum ? 16'd0 : sums.source_sum;
    for (int k = 0; k < 3; k++) begin
      if ({1'b0, stage.real_bytes} > 3'(k)) begin
        src = sum_step(src, stage.data_bytes[k]);
      end
    end

    // Text sum over the length and data characters, then the line end
    enc = stage.clear_section_sum ? 16'd0 : sums.encoded_sum;
    for (int k = 0; k < SLOT_CR; k++) begin
      if (stage.present[k]) begin
        enc = sum_step(enc, stage.chars[k]);
      end
    end
    if (stage.last_group) begin
      enc = sum_step(enc, CHAR_LF);
    end

    sums_nxt.source_sum  = src;
    sums_nxt.encoded_sum = enc;
  end

endmodule

`default_nettype wire
